FILE: rtl/mi3_pkg.sv
// ---------------------------------------------------------------------------
// mi3_pkg
// Shared widths, types and constants for the 3x3 fixed-point matrix inverse.
// ---------------------------------------------------------------------------
package mi3_pkg;

  // fraction bits of the element format
  localparam int FRAC_BITS = 16;
  // element width (signed)
  localparam int EW = 32;
  // signed cofactor width and its magnitude width
  localparam int CW = 66;
  localparam int CMW = 65;
  // signed determinant width and its magnitude width
  localparam int DW = 98;
  localparam int DMW = 97;
  // scale applied to the numerator before the divide
  localparam int SH = 2 * FRAC_BITS;
  // numerator width
  localparam int NW = CMW + SH;
  // quotient bits developed by the divider, above that is overflow
  localparam int QB = 33;
  // remainder width
  localparam int RW = DMW + 1;
  // width of the overflow compare
  localparam int OW = (NW > DMW + QB) ? NW : DMW + QB;
  // low split of a cofactor for the determinant multipliers
  localparam int LO_W = 33;
  // divider latency in cycles
  localparam int DIV_LAT = QB + 1;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;
  typedef elem_t mat_t [9];
  typedef elem_t col_t [3];
  typedef cof_t cofm_t [9];

endpackage

FILE: rtl/mi3_cofactor.sv
// ---------------------------------------------------------------------------
// mi3_cofactor
// Two-stage cofactor unit: eighteen 32x32 products, then nine differences.
// ---------------------------------------------------------------------------
module mi3_cofactor (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  mi3_pkg::mat_t  m_in,
  output logic           out_vld,
  output mi3_pkg::col_t  col_out,
  output mi3_pkg::cofm_t cof_out
);
  import mi3_pkg::*;

  logic signed [2*EW-1:0] pa [9];
  logic signed [2*EW-1:0] pb [9];
  col_t col1;
  logic vld1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  // first column travels along for the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      col1[0] <= m_in[0];
      col1[1] <= m_in[1];
      col1[2] <= m_in[2];
      col_out <= col1;
    end
  end

  // one cofactor per row and column, flat index 3*col+row
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int K  = 3 * c + r;
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          pa[K]      <= m_in[3*C1+R1] * m_in[3*C2+R2];
          pb[K]      <= m_in[3*C2+R1] * m_in[3*C1+R2];
          cof_out[K] <= cof_t'(pa[K]) - cof_t'(pb[K]);
        end
      end
    end
  end

endmodule

FILE: rtl/mi3_det.sv
// ---------------------------------------------------------------------------
// mi3_det
// Three-stage determinant along the first column, cofactors delayed to match.
// ---------------------------------------------------------------------------
module mi3_det (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  mi3_pkg::col_t  col_in,
  input  mi3_pkg::cofm_t cof_in,
  output logic           out_vld,
  output mi3_pkg::det_t  det_out,
  output mi3_pkg::cofm_t cof_out
);
  import mi3_pkg::*;

  logic signed [EW+LO_W:0]     lo [3];
  logic signed [EW+CW-LO_W-1:0] hi [3];
  det_t  row [3];
  cofm_t cofa;
  cofm_t cofb;
  logic  vlda;
  logic  vldb;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vlda    <= 1'b0;
      vldb    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vlda    <= in_vld;
      vldb    <= vlda;
      out_vld <= vldb;
    end
  end

  // split products, partial sums, final sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        lo[r]  <= col_in[r] * $signed({1'b0, cof_in[r][LO_W-1:0]});
        hi[r]  <= col_in[r] * $signed(cof_in[r][CW-1:LO_W]);
        row[r] <= (det_t'(hi[r]) <<< LO_W) + det_t'(lo[r]);
      end
      det_out <= row[0] + row[1] + row[2];
      cofa    <= cof_in;
      cofb    <= cofa;
      cof_out <= cofb;
    end
  end

endmodule

FILE: rtl/mi3_div.sv
// ---------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider lane, one quotient bit per stage plus overflow.
// ---------------------------------------------------------------------------
module mi3_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [mi3_pkg::NW-1:0]   num,
  input  logic [mi3_pkg::DMW-1:0]  dmag,
  input  logic                     neg,
  output logic                     out_vld,
  output logic [mi3_pkg::QB-1:0]   q,
  output logic                     ovf,
  output logic                     neg_out
);
  import mi3_pkg::*;

  logic            s_vld  [QB+1];
  logic [RW-1:0]   s_rem  [QB+1];
  logic [QB-1:0]   s_q    [QB+1];
  logic [NW-1:0]   s_num  [QB+1];
  logic [DMW-1:0]  s_dmag [QB+1];
  logic            s_neg  [QB+1];
  logic            s_ovf  [QB+1];

  // entry stage: overflow check and top bits of the numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld[0] <= 1'b0;
    end else if (en) begin
      s_vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem[0]  <= RW'(num >> QB);
      s_ovf[0]  <= OW'(num) >= (OW'(dmag) << QB);
      s_q[0]    <= '0;
      s_num[0]  <= num;
      s_dmag[0] <= dmag;
      s_neg[0]  <= neg;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = {s_rem[i][RW-2:0], s_num[i][QB-1-i]};
      ge    = trial >= RW'(s_dmag[i]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_vld[i+1] <= 1'b0;
      end else if (en) begin
        s_vld[i+1] <= s_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[i+1]  <= ge ? trial - RW'(s_dmag[i]) : trial;
        s_q[i+1]    <= {s_q[i][QB-2:0], ge};
        s_num[i+1]  <= s_num[i];
        s_dmag[i+1] <= s_dmag[i];
        s_neg[i+1]  <= s_neg[i];
        s_ovf[i+1]  <= s_ovf[i];
      end
    end
  end

  assign out_vld = s_vld[QB];
  assign q       = s_q[QB];
  assign ovf     = s_ovf[QB];
  assign neg_out = s_neg[QB];

endmodule

FILE: rtl/matrix_inverse_3x3.sv
// ---------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 Q16.16 matrix inverse by adjugate with determinant and singular flag.
// ---------------------------------------------------------------------------
//  channel | handshake            | beat
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | elem0..elem8, column-major matrix
//  out     | out_valid / out_stall| inv0..inv8, det_value, singular
//
//  one beat accepted per cycle while the output is not stalled; stages in order:
//  2 cofactor, 3 determinant, 1 prep, 34 divider stages, 1 output register
//  the divider lanes (one quotient bit per stage) set the depth
//  reset clears the valid bits only
//  a stalled output holds the whole pipeline, in_stall follows it
// ---------------------------------------------------------------------------
module matrix_inverse_3x3 (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mi3_pkg::elem_t elem0,
  input  mi3_pkg::elem_t elem1,
  input  mi3_pkg::elem_t elem2,
  input  mi3_pkg::elem_t elem3,
  input  mi3_pkg::elem_t elem4,
  input  mi3_pkg::elem_t elem5,
  input  mi3_pkg::elem_t elem6,
  input  mi3_pkg::elem_t elem7,
  input  mi3_pkg::elem_t elem8,
  output logic           out_valid,
  input  logic           out_stall,
  output mi3_pkg::elem_t inv0,
  output mi3_pkg::elem_t inv1,
  output mi3_pkg::elem_t inv2,
  output mi3_pkg::elem_t inv3,
  output mi3_pkg::elem_t inv4,
  output mi3_pkg::elem_t inv5,
  output mi3_pkg::elem_t inv6,
  output mi3_pkg::elem_t inv7,
  output mi3_pkg::elem_t inv8,
  output mi3_pkg::elem_t det_value,
  output logic           singular
);
  import mi3_pkg::*;

  localparam elem_t EMAX = {1'b0, {(EW-1){1'b1}}};
  localparam elem_t EMIN = {1'b1, {(EW-1){1'b0}}};

  logic  en;
  mat_t  m_in;
  logic  c_vld;
  col_t  c_col;
  cofm_t c_cof;
  logic  d_vld;
  det_t  d_det;
  cofm_t d_cof;

  logic            p_vld;
  logic [NW-1:0]   p_num [9];
  logic            p_neg [9];
  logic [DMW-1:0]  p_dmag;
  det_t            p_det;
  logic            p_zero;

  logic            q_vld [9];
  logic [QB-1:0]   q_val [9];
  logic            q_ovf [9];
  logic            q_neg [9];

  logic            dl_vld  [DIV_LAT];
  det_t            dl_det  [DIV_LAT];
  logic            dl_zero [DIV_LAT];

  elem_t inv_q [9];
  det_t  det_sh;

  // whole pipeline moves unless a result waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign m_in[0] = elem0;
  assign m_in[1] = elem1;
  assign m_in[2] = elem2;
  assign m_in[3] = elem3;
  assign m_in[4] = elem4;
  assign m_in[5] = elem5;
  assign m_in[6] = elem6;
  assign m_in[7] = elem7;
  assign m_in[8] = elem8;

  mi3_cofactor u_cof (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .m_in    (m_in),
    .out_vld (c_vld),
    .col_out (c_col),
    .cof_out (c_cof)
  );

  mi3_det u_det (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (c_vld),
    .col_in  (c_col),
    .cof_in  (c_cof),
    .out_vld (d_vld),
    .det_out (d_det),
    .cof_out (d_cof)
  );

  // prep stage: magnitudes, signs and scaled numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_dmag <= DMW'(d_det[DW-1] ? -d_det : d_det);
      p_det  <= d_det;
      p_zero <= (d_det == '0);
      // inverse element 3c+r divides cofactor at row c, column r
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          p_neg[3*c+r] <= d_cof[3*r+c][CW-1] ^ d_det[DW-1];
          p_num[3*c+r] <= {CMW'(d_cof[3*r+c][CW-1] ? -d_cof[3*r+c] : d_cof[3*r+c]),
                           {SH{1'b0}}};
        end
      end
    end
  end

  // nine divider lanes
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (p_vld),
      .num     (p_num[k]),
      .dmag    (p_dmag),
      .neg     (p_neg[k]),
      .out_vld (q_vld[k]),
      .q       (q_val[k]),
      .ovf     (q_ovf[k]),
      .neg_out (q_neg[k])
    );
  end

  // determinant and zero flag wait for the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl_vld[i] <= 1'b0;
      end
    end else if (en) begin
      dl_vld[0] <= p_vld;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_vld[i] <= dl_vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_det[0]  <= p_det;
      dl_zero[0] <= p_zero;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_det[i]  <= dl_det[i-1];
        dl_zero[i] <= dl_zero[i-1];
      end
    end
  end

  // signed saturation of a quotient magnitude
  function automatic elem_t sat_q(logic o, logic [QB-1:0] qm, logic n);
    logic [QB:0] qv;
    logic [QB:0] lim;
    elem_t       res;
    qv       = {o, qm};
    lim      = '0;
    lim[EW-1] = 1'b1;
    if (n) begin
      res = (qv > lim) ? EMIN : elem_t'(-qm[EW-1:0]);
    end else begin
      res = (qv >= lim) ? EMAX : elem_t'(qm[EW-1:0]);
    end
    return res;
  endfunction

  assign det_sh = dl_det[DIV_LAT-1] >>> SH;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      singular <= dl_zero[DIV_LAT-1];
      for (int k = 0; k < 9; k++) begin
        inv_q[k] <= dl_zero[DIV_LAT-1] ? '0 : sat_q(q_ovf[k], q_val[k], q_neg[k]);
      end
      if ((&det_sh[DW-1:EW-1]) || !(|det_sh[DW-1:EW-1])) begin
        det_value <= det_sh[EW-1:0];
      end else begin
        det_value <= det_sh[DW-1] ? EMIN : EMAX;
      end
    end
  end

  assign inv0 = inv_q[0];
  assign inv1 = inv_q[1];
  assign inv2 = inv_q[2];
  assign inv3 = inv_q[3];
  assign inv4 = inv_q[4];
  assign inv5 = inv_q[5];
  assign inv6 = inv_q[6];
  assign inv7 = inv_q[7];
  assign inv8 = inv_q[8];

`ifndef SYNTHESIS
  // divider lanes and the determinant delay line stay aligned
  a_align: assert property (@(posedge clk) disable iff (rst)
    q_vld[0] == dl_vld[DIV_LAT-1])
    else $error("divider and determinant delay out of step");

  // a singular result carries zero diagonal inverse elements and a zero determinant
  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> inv0 == '0 && inv4 == '0 && inv8 == '0 &&
      det_value == '0)
    else $error("singular result with nonzero fields");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
